### design/chained_hash_table_core_defines.svh
// Assertion macros for the chained hash table core.
`ifndef CHAINED_HASH_TABLE_CORE_DEFINES_SVH
`define CHAINED_HASH_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define CHT_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHT_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

### design/cht_pkg.sv
// Package: constants, types and encodings of the chained hash table.
`default_nettype none
package cht_pkg;
  localparam int NODES     = 256;
  localparam int BUCKETS   = 256;
  localparam int NODE_W    = $clog2(NODES);
  localparam int BKT_W     = $clog2(BUCKETS);
  localparam int LINK_W    = NODE_W + 1;
  localparam int STEP_W    = NODE_W + 1;
  localparam int SCAN_W    = BKT_W + 1;
  localparam int HASH_W    = 32;
  localparam int CNT_W     = 9;
  localparam int BBITS_W   = 4;
  localparam int MODE_W    = 3;
  localparam int POS_W     = 8;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam logic [BBITS_W-1:0] BBITS_RST = 4'd8;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 9'd511;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_FIND   = 3'd2,
    MODE_POS    = 3'd3,
    MODE_NEXT   = 3'd4,
    MODE_FIRST  = 3'd5,
    MODE_CLEAR  = 3'd6,
    MODE_NONE   = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_HASH_WAIT,
    ST_HEAD_WAIT,
    ST_WALK_ISSUE,
    ST_WALK_EVAL,
    ST_NEXT_WAIT,
    ST_SCAN,
    ST_SCAN_RD,
    ST_DONE
  } state_t;

  // Requests from the controller to the storage.
  typedef struct packed {
    logic [BKT_W-1:0]  head_raddr;
    logic              head_we;
    logic [BKT_W-1:0]  head_waddr;
    logic [LINK_W-1:0] head_wdata;
    logic              clr_all;
    logic [NODE_W-1:0] link_raddr;
    logic              link_we;
    logic [NODE_W-1:0] link_waddr;
    logic [LINK_W-1:0] link_wdata;
    logic [NODE_W-1:0] hash_raddr;
    logic              hash_we;
    logic [NODE_W-1:0] hash_waddr;
    logic [HASH_W-1:0] hash_wdata;
    logic [BKT_W-1:0]  vld_addr;
  } store_req_t;

  typedef struct packed {
    logic [LINK_W-1:0] head_q;
    logic [LINK_W-1:0] link_q;
    logic [HASH_W-1:0] hash_q;
    logic              vld;
  } store_rsp_t;
endpackage
`default_nettype wire

### design/cht_store.sv
// Storage: bucket heads with valid bits, next links and node hashes.
`default_nettype none
module cht_store (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cht_pkg::store_req_t req,
  output cht_pkg::store_rsp_t    rsp
);
  logic [cht_pkg::NODE_W-1:0] head_mem [cht_pkg::BUCKETS];
  logic [cht_pkg::LINK_W-1:0] link_mem [cht_pkg::NODES];
  logic [cht_pkg::HASH_W-1:0] hash_mem [cht_pkg::NODES];
  logic [cht_pkg::BUCKETS-1:0] vld_r;
  logic [cht_pkg::NODE_W-1:0] head_rd_r;
  logic                       head_vld_r;
  logic [cht_pkg::LINK_W-1:0] link_rd_r;
  logic [cht_pkg::HASH_W-1:0] hash_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr_all) begin
      vld_r <= '0;
    end else if (req.head_we) begin
      vld_r[req.head_waddr] <= req.head_wdata[cht_pkg::LINK_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (req.head_we) begin
      head_mem[req.head_waddr] <= req.head_wdata[cht_pkg::NODE_W-1:0];
    end
    head_rd_r  <= head_mem[req.head_raddr];
    head_vld_r <= vld_r[req.head_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      link_mem[req.link_waddr] <= req.link_wdata;
    end
    link_rd_r <= link_mem[req.link_raddr];
  end

  always_ff @(posedge clk) begin
    if (req.hash_we) begin
      hash_mem[req.hash_waddr] <= req.hash_wdata;
    end
    hash_rd_r <= hash_mem[req.hash_raddr];
  end

  assign rsp.head_q = {head_vld_r, head_rd_r};
  assign rsp.link_q = link_rd_r;
  assign rsp.hash_q = hash_rd_r;
  assign rsp.vld    = vld_r[req.vld_addr];
endmodule
`default_nettype wire

### design/cht_ctrl.sv
// Controller: request decode, chain walk, bucket scan and result register.
`default_nettype none
module cht_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [cht_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cht_pkg::BBITS_W-1:0]   cfg_data,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [cht_pkg::OUT_DATA_W-1:0]     out_tdata,
  output cht_pkg::store_req_t                req,
  input  wire cht_pkg::store_rsp_t           rsp
);
  localparam int NW = cht_pkg::NODE_W;
  localparam int BW = cht_pkg::BKT_W;
  localparam int LW = cht_pkg::LINK_W;
  localparam int SW = cht_pkg::SCAN_W;

  cht_pkg::state_t state_r, state_nxt;
  cht_pkg::mode_t  mode_r, mode_nxt, in_mode;
  logic [NW-1:0] id_r, id_nxt, prev_r, prev_nxt, nout_r, nout_nxt, in_id;
  logic [cht_pkg::HASH_W-1:0] hash_r, hash_nxt, in_hash;
  logic [BW-1:0] bkt_r, bkt_nxt, mask;
  logic [LW-1:0] cur_r, cur_nxt;
  logic          pred_head_r, pred_head_nxt, hit_r, hit_nxt;
  logic [cht_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic [SW-1:0] scan_r, scan_nxt, lim;
  logic [cht_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [cht_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [cht_pkg::BBITS_W-1:0] bbits_r, ubits;
  logic          out_valid_r, out_valid_nxt;
  logic [cht_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic          match;

  assign in_mode = cht_pkg::mode_t'(in_tdata[2:0]);
  assign in_id   = in_tdata[3 +: NW];
  assign in_hash = in_tdata[11 +: cht_pkg::HASH_W];

  assign ubits = (bbits_r > cht_pkg::BBITS_W'(BW)) ? cht_pkg::BBITS_W'(BW) : bbits_r;
  assign mask  = BW'((SW'(1) << ubits) - SW'(1));
  assign lim   = SW'(1) << ubits;

  assign in_tready  = (state_r == cht_pkg::ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cht_pkg::ST_IDLE;
      count_r     <= '0;
      bbits_r     <= cht_pkg::BBITS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        bbits_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    id_r        <= id_nxt;
    hash_r      <= hash_nxt;
    bkt_r       <= bkt_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    pred_head_r <= pred_head_nxt;
    steps_r     <= steps_nxt;
    scan_r      <= scan_nxt;
    hit_r       <= hit_nxt;
    nout_r      <= nout_nxt;
    pos_r       <= pos_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    id_nxt        = id_r;
    hash_nxt      = hash_r;
    bkt_nxt       = bkt_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    pred_head_nxt = pred_head_r;
    steps_nxt     = steps_r;
    scan_nxt      = scan_r;
    hit_nxt       = hit_r;
    nout_nxt      = nout_r;
    pos_nxt       = pos_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    req           = '0;
    req.vld_addr  = scan_r[BW-1:0];
    match = (mode_r == cht_pkg::MODE_FIND) ? (rsp.hash_q == hash_r)
                                           : (cur_r[NW-1:0] == id_r);
    unique case (state_r)
      cht_pkg::ST_IDLE: begin
        hit_nxt  = 1'b0;
        nout_nxt = '0;
        pos_nxt  = '0;
        if (in_tvalid) begin
          mode_nxt = in_mode;
          id_nxt   = in_id;
          hash_nxt = in_hash;
          bkt_nxt  = in_hash[BW-1:0] & mask;
          req.head_raddr = in_hash[BW-1:0] & mask;
          req.hash_raddr = in_id;
          req.link_raddr = in_id;
          unique case (in_mode)
            cht_pkg::MODE_INSERT: state_nxt = cht_pkg::ST_INS;
            cht_pkg::MODE_DELETE,
            cht_pkg::MODE_POS:    state_nxt = cht_pkg::ST_HASH_WAIT;
            cht_pkg::MODE_FIND:   state_nxt = cht_pkg::ST_HEAD_WAIT;
            cht_pkg::MODE_NEXT:   state_nxt = cht_pkg::ST_NEXT_WAIT;
            cht_pkg::MODE_FIRST: begin
              scan_nxt  = '0;
              state_nxt = cht_pkg::ST_SCAN;
            end
            cht_pkg::MODE_CLEAR: begin
              req.clr_all = 1'b1;
              count_nxt   = '0;
              state_nxt   = cht_pkg::ST_DONE;
            end
            default: state_nxt = cht_pkg::ST_DONE;
          endcase
        end
      end
      cht_pkg::ST_INS: begin
        req.hash_we    = 1'b1;
        req.hash_waddr = id_r;
        req.hash_wdata = hash_r;
        req.link_we    = 1'b1;
        req.link_waddr = id_r;
        req.link_wdata = rsp.head_q;
        req.head_we    = 1'b1;
        req.head_waddr = bkt_r;
        req.head_wdata = {1'b1, id_r};
        if (count_r != cht_pkg::CNT_MAX) begin
          count_nxt = count_r + 1'b1;
        end
        hit_nxt   = 1'b1;
        state_nxt = cht_pkg::ST_DONE;
      end
      cht_pkg::ST_HASH_WAIT: begin
        bkt_nxt        = rsp.hash_q[BW-1:0] & mask;
        req.head_raddr = rsp.hash_q[BW-1:0] & mask;
        state_nxt      = cht_pkg::ST_HEAD_WAIT;
      end
      cht_pkg::ST_HEAD_WAIT: begin
        cur_nxt       = rsp.head_q;
        steps_nxt     = '0;
        pred_head_nxt = 1'b1;
        state_nxt     = cht_pkg::ST_WALK_ISSUE;
      end
      cht_pkg::ST_WALK_ISSUE: begin
        if (!cur_r[LW-1] || steps_r[cht_pkg::STEP_W-1]) begin
          state_nxt = cht_pkg::ST_DONE;
        end else begin
          req.link_raddr = cur_r[NW-1:0];
          req.hash_raddr = cur_r[NW-1:0];
          state_nxt      = cht_pkg::ST_WALK_EVAL;
        end
      end
      cht_pkg::ST_WALK_EVAL: begin
        if (match) begin
          hit_nxt   = 1'b1;
          state_nxt = cht_pkg::ST_DONE;
          if (mode_r == cht_pkg::MODE_FIND) begin
            nout_nxt = cur_r[NW-1:0];
          end else if (mode_r == cht_pkg::MODE_POS) begin
            pos_nxt = steps_r[cht_pkg::POS_W-1:0];
          end else begin
            if (pred_head_r) begin
              req.head_we    = 1'b1;
              req.head_waddr = bkt_r;
              req.head_wdata = rsp.link_q;
            end else begin
              req.link_we    = 1'b1;
              req.link_waddr = prev_r;
              req.link_wdata = rsp.link_q;
            end
            if (count_r != '0) begin
              count_nxt = count_r - 1'b1;
            end
          end
        end else begin
          prev_nxt      = cur_r[NW-1:0];
          pred_head_nxt = 1'b0;
          cur_nxt       = rsp.link_q;
          steps_nxt     = steps_r + 1'b1;
          state_nxt     = cht_pkg::ST_WALK_ISSUE;
        end
      end
      cht_pkg::ST_NEXT_WAIT: begin
        if (rsp.link_q[LW-1]) begin
          hit_nxt   = 1'b1;
          nout_nxt  = rsp.link_q[NW-1:0];
          state_nxt = cht_pkg::ST_DONE;
        end else begin
          scan_nxt  = SW'(rsp.hash_q[BW-1:0] & mask) + 1'b1;
          state_nxt = cht_pkg::ST_SCAN;
        end
      end
      cht_pkg::ST_SCAN: begin
        if (scan_r >= lim) begin
          state_nxt = cht_pkg::ST_DONE;
        end else if (rsp.vld) begin
          req.head_raddr = scan_r[BW-1:0];
          state_nxt      = cht_pkg::ST_SCAN_RD;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      cht_pkg::ST_SCAN_RD: begin
        hit_nxt   = 1'b1;
        nout_nxt  = rsp.head_q[NW-1:0];
        state_nxt = cht_pkg::ST_DONE;
      end
      cht_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, (count_r == '0), count_r, pos_r, nout_r, hit_r};
          state_nxt     = cht_pkg::ST_IDLE;
        end
      end
      default: state_nxt = cht_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### design/chained_hash_table_core.sv
// Insert writes head, link and hash together; clear and unused mode go straight to the result.
// Delete and position first read the node's hash, then the bucket head; find reads the head.
// All three then walk the chain; next ends on a link hit, else it scans buckets like first.
// One request at a time; each chain node costs a link/hash read and a compare.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_n, synchronous, active low) empties all buckets, zeroes count, bucket_bits 8.
`default_nettype none
module chained_hash_table_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // mode[2:0], node_id[10:3], hash[42:11], zero fill
  input  wire logic [47:0] in_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // hit[0], node_out[8:1], position[16:9], node_count[25:17], is_empty[26], zero fill
  output logic [31:0]      out_tdata
);
  cht_pkg::store_req_t req;
  cht_pkg::store_rsp_t rsp;

  cht_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .req        (req),
    .rsp        (rsp)
  );

  cht_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );
endmodule
`default_nettype wire

### design/cht_checker.sv
// Port-level checker for the chained hash table core, with its bind.
`default_nettype none
`include "chained_hash_table_core_defines.svh"
module cht_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);
  `CHT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")
  `CHT_ASSERT_IMP(a_empty_flag, out_tvalid, out_tdata[26] == (out_tdata[25:17] == 9'd0), "is_empty disagrees with node_count")
  `CHT_ASSERT_IMP(a_miss_zero, out_tvalid && !out_tdata[0], out_tdata[16:1] == 16'd0, "miss with nonzero node or position")
  `CHT_ASSERT_NXT(a_busy, in_tvalid && in_tready, !in_tready, "request taken while busy")
endmodule

bind chained_hash_table_core cht_checker u_cht_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

### test/chained_hash_table_core_checker.sv
// Checker for the chained hash table core: models the table and compares every result.
module chained_hash_table_core_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [47:0] in_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [31:0] out_tdata,
  output int               errors,
  output int               pending,
  output int               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // hit lowest, as packed on out_tdata
  typedef struct packed {
    logic       is_empty;
    logic [8:0] node_count;
    logic [7:0] position;
    logic [7:0] node_out;
    logic       hit;
  } result_t;

  logic [8:0]  tbl_heads [cht_pkg::BUCKETS];
  logic [8:0]  tbl_links [cht_pkg::NODES];
  logic [31:0] tbl_hashes [cht_pkg::NODES];
  logic [8:0]  tbl_count;
  logic [3:0]  tbl_bbits;
  result_t     expected_results [$];
  int          err_cnt;
  int          chk_cnt;

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  function automatic logic [7:0] bucket_of(logic [31:0] h);
    int nb;
    nb = (tbl_bbits > 4'd8) ? 8 : int'(tbl_bbits);
    return h[7:0] & 8'((1 << nb) - 1);
  endfunction

  function automatic logic [8:0] scan_from(int start);
    int nb;
    nb = (tbl_bbits > 4'd8) ? 8 : int'(tbl_bbits);
    for (int b = start; b < (1 << nb); b++) begin
      if (tbl_heads[b][8]) return tbl_heads[b];
    end
    return 9'd0;
  endfunction

  function automatic result_t table_step(cht_pkg::mode_t mode, logic [7:0] id,
                                         logic [31:0] h);
    result_t    r;
    logic [7:0] b;
    logic [8:0] lnk;
    logic [7:0] cur;
    int         prev;
    r = '0;
    case (mode)
      cht_pkg::MODE_INSERT: begin
        b = bucket_of(h);
        tbl_hashes[id] = h;
        tbl_links[id] = tbl_heads[b];
        tbl_heads[b] = {1'b1, id};
        if (tbl_count < cht_pkg::CNT_MAX) tbl_count++;
        r.hit = 1'b1;
      end
      cht_pkg::MODE_DELETE, cht_pkg::MODE_POS: begin
        b = bucket_of(tbl_hashes[id]);
        lnk = tbl_heads[b];
        prev = -1;
        for (int s = 0; s < cht_pkg::NODES && lnk[8]; s++) begin
          cur = lnk[7:0];
          if (cur == id) begin
            r.hit = 1'b1;
            if (mode == cht_pkg::MODE_POS) begin
              r.position = (s > 255) ? 8'd255 : 8'(s);
            end else begin
              if (prev < 0) tbl_heads[b] = tbl_links[id];
              else tbl_links[prev] = tbl_links[id];
              if (tbl_count > 0) tbl_count--;
            end
            break;
          end
          prev = cur;
          lnk = tbl_links[cur];
        end
      end
      cht_pkg::MODE_FIND: begin
        lnk = tbl_heads[bucket_of(h)];
        for (int s = 0; s < cht_pkg::NODES && lnk[8]; s++) begin
          cur = lnk[7:0];
          if (tbl_hashes[cur] == h) begin
            r.hit = 1'b1;
            r.node_out = cur;
            break;
          end
          lnk = tbl_links[cur];
        end
      end
      cht_pkg::MODE_NEXT: begin
        if (tbl_links[id][8]) lnk = tbl_links[id];
        else lnk = scan_from(int'(bucket_of(tbl_hashes[id])) + 1);
        r.hit = lnk[8];
        r.node_out = lnk[8] ? lnk[7:0] : 8'd0;
      end
      cht_pkg::MODE_FIRST: begin
        lnk = scan_from(0);
        r.hit = lnk[8];
        r.node_out = lnk[8] ? lnk[7:0] : 8'd0;
      end
      cht_pkg::MODE_CLEAR: begin
        for (int i = 0; i < cht_pkg::BUCKETS; i++) tbl_heads[i] = 9'd0;
        tbl_count = 9'd0;
      end
      default: ;
    endcase
    r.node_count = tbl_count;
    r.is_empty = (tbl_count == 0);
    return r;
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d actual %0d", $realtime, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < cht_pkg::BUCKETS; i++) tbl_heads[i] = 9'd0;
      for (int i = 0; i < cht_pkg::NODES; i++) begin
        tbl_links[i] = 9'd0;
        tbl_hashes[i] = 32'd0;
      end
      tbl_count = 9'd0;
      tbl_bbits = cht_pkg::BBITS_RST;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[26:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $realtime, out_tdata);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", want.hit, got.hit);
          check_field("node_out", want.node_out, got.node_out);
          check_field("position", want.position, got.position);
          check_field("node_count", want.node_count, got.node_count);
          check_field("is_empty", want.is_empty, got.is_empty);
          chk_cnt++;
        end
      end
      if (cfg_valid && cfg_ready) tbl_bbits = cfg_data;
      if (in_tvalid && in_tready)
        expected_results.push_back(table_step(cht_pkg::mode_t'(in_tdata[2:0]),
                                              in_tdata[10:3], in_tdata[42:11]));
    end
    errors  <= err_cnt;
    pending <= expected_results.size();
    checked <= chk_cnt;
  end
endmodule

### test/chained_hash_table_core_tb.sv
// Testbench top for the chained hash table core: stimulus, flow control and verdict.
module chained_hash_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  int          errors;
  int          pending;
  int          checked;

  bit          seen [cht_pkg::NODES];
  logic [31:0] seen_hash [cht_pkg::NODES];
  logic [7:0]  seen_ids [$];
  int          burst_left;
  int          n_req;

  always #5 clk = ~clk;

  chained_hash_table_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  chained_hash_table_core_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    #20ms;
    $display("chained_hash_table_core: mismatch");
    $finish;
  end

  // request: hold valid for a following request when hold is set
  task automatic send_req(cht_pkg::mode_t mode, logic [7:0] id, logic [31:0] h, bit hold);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, h, id, mode};
    if (mode == cht_pkg::MODE_INSERT) begin
      if (!seen[id]) seen_ids.push_back(id);
      seen[id] = 1'b1;
      seen_hash[id] = h;
    end
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_req++;
    if (!hold) in_tvalid <= 1'b0;
  endtask

  task automatic paced_req(cht_pkg::mode_t mode, logic [7:0] id, logic [31:0] h);
    bit hold;
    if (burst_left == 0) burst_left = $urandom_range(1, 12);
    burst_left--;
    hold = (burst_left != 0);
    send_req(mode, id, h, hold);
    if (!hold) repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  // stop offering and wait until every taken request has its result
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic random_req();
    int             r;
    cht_pkg::mode_t mode;
    logic [7:0]     id;
    logic [31:0]    h;
    r = $urandom_range(0, 99);
    id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
    h = $urandom;
    if ($urandom_range(0, 1)) h[7:0] = 8'($urandom_range(0, 3));
    if (r < 35 || seen_ids.size() == 0) mode = cht_pkg::MODE_INSERT;
    else if (r < 50) mode = cht_pkg::MODE_DELETE;
    else if (r < 62) mode = cht_pkg::MODE_FIND;
    else if (r < 75) mode = cht_pkg::MODE_POS;
    else if (r < 88) mode = cht_pkg::MODE_NEXT;
    else if (r < 94) mode = cht_pkg::MODE_FIRST;
    else if (r < 97) mode = cht_pkg::MODE_CLEAR;
    else mode = cht_pkg::MODE_NONE;
    if (mode inside {cht_pkg::MODE_DELETE, cht_pkg::MODE_POS, cht_pkg::MODE_NEXT})
      id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
    if (mode == cht_pkg::MODE_FIND && seen_ids.size() != 0 && $urandom_range(0, 9) < 6)
      h = seen_hash[seen_ids[$urandom_range(0, seen_ids.size() - 1)]];
    paced_req(mode, id, h);
  endtask

  task automatic write_bbits(logic [3:0] v);
    drain();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: own stall pattern, one long hold-off while requests keep coming
  initial begin
    int  cyc;
    int  n;
    bit  held;
    out_tready <= 1'b0;
    cyc = 0;
    held = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && cyc > 600) begin
        held = 1;
        repeat (400) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      n = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0: repeat (n) begin out_tready <= 1'b1; @(posedge clk); end
        1: repeat (n) begin out_tready <= 1'($urandom); @(posedge clk); end
        2: repeat (n % 9 + 1) begin out_tready <= 1'b0; @(posedge clk); end
        default: for (int i = 0; i < n; i++) begin
          out_tready <= i[0];
          @(posedge clk);
        end
      endcase
      cyc += n;
    end
  end

  initial begin
    logic [3:0] bbits_seq [6];
    bbits_seq  = '{4'd8, 4'd0, 4'd3, 4'd15, 4'd1, 4'd8};
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    burst_left = 0;
    n_req = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, collisions, absent nodes, stale link, double insert cycle
    paced_req(cht_pkg::MODE_INSERT, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_INSERT, 8'd255, 32'hffff_ffff);
    paced_req(cht_pkg::MODE_INSERT, 8'd1, 32'h100);
    paced_req(cht_pkg::MODE_FIND, 8'd0, 32'h100);
    paced_req(cht_pkg::MODE_FIND, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_FIND, 8'd255, 32'hdead_beef);
    paced_req(cht_pkg::MODE_POS, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_POS, 8'd1, 32'hffff_ffff);
    paced_req(cht_pkg::MODE_NEXT, 8'd1, 32'h0);
    paced_req(cht_pkg::MODE_NEXT, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_NEXT, 8'd255, 32'h0);
    paced_req(cht_pkg::MODE_FIRST, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_DELETE, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_DELETE, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_NEXT, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_POS, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_INSERT, 8'd1, 32'h100);
    paced_req(cht_pkg::MODE_POS, 8'd1, 32'h0);
    paced_req(cht_pkg::MODE_FIND, 8'd0, 32'h200);
    paced_req(cht_pkg::MODE_NONE, 8'd255, 32'hffff_ffff);
    paced_req(cht_pkg::MODE_CLEAR, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_FIRST, 8'd0, 32'h0);
    paced_req(cht_pkg::MODE_DELETE, 8'd1, 32'h0);
    paced_req(cht_pkg::MODE_NEXT, 8'd255, 32'h0);

    foreach (bbits_seq[p]) begin
      write_bbits(bbits_seq[p]);
      repeat (100) random_req();
    end

    drain();
    repeat (50) @(posedge clk);
    $display("%0d requests sent, %0d results checked, over six bucket_bits values",
             n_req, checked);
    $display("covered insert, delete, find, position, next, first, clear and unused mode");
    if (errors == 0) begin
      $display("chained_hash_table_core: match");
    end else begin
      $display("chained_hash_table_core: mismatch");
    end
    $finish;
  end
endmodule
